// ===== rtl/core/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Payload types, register map and fixed sizes shared by the block and its
// stream interfaces.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int CFG_W      = 13;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 12;
    localparam int MAG_W      = 11;
    localparam int SUM_W      = 10;
    localparam int MIN_SIZE   = 3;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
    } t_pix;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [MAG_W-1:0] magnitude;
        logic [PIX_W-1:0] edge_byte;
        logic             last_of_frame;
    } t_res;

endpackage

// ===== rtl/core/sem_stream_if.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface sem_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sobel_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streaming 3x3 Sobel |Gx|+|Gy| over a raster pixel stream, with both line
// buffers held in one synchronous memory read and written back per pixel.
//
//   Channel   Dir   Payload                                   Transfer
//   i_pix     in    pixel                                     valid & ready
//   o_res     out   out_row, out_col, magnitude, edge_byte,   valid & ready
//                   last_of_frame
//   APB       in    image_width (0x0), image_height (0x4)     psel & penable & pwrite
//
// One pixel per cycle while o_res is not stalled; a result passes through the line-memory
// read register and then the output register after its pixel transfer.
// Border pixels produce no result. Synchronous active-low reset clears the
// position, the window and the sizes (640 x 480); line memory is not cleared.
// A stalled output register holds the memory stage, which in turn holds i_pix.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sem_stream_if.sink                 i_pix,
    sem_stream_if.source               o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sem_pkg::APB_AW-1:0] paddr,
    input  logic [sem_pkg::APB_DW-1:0] pwdata,
    output logic [sem_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import sem_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CW1 = $clog2(MAX_WIDTH + 1);
    localparam int RW1 = $clog2(MAX_HEIGHT + 1);
    localparam int WW  = (CW1 > CFG_W) ? CW1 : CFG_W;
    localparam int HW  = (RW1 > CFG_W) ? RW1 : CFG_W;
    localparam int LW  = 2 * PIX_W;

    // configuration
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic             cfg_wr;
    logic [WW-1:0]    cfg_w_ext;
    logic [HW-1:0]    cfg_h_ext;
    logic [WW-1:0]    w_lim;
    logic [HW-1:0]    h_lim;

    // position and front stage
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    n_row;
    logic             in_xfer;
    logic             wrap;
    logic [WW-1:0]    c_eff;
    logic [HW-1:0]    r_pre;
    logic [HW-1:0]    r_eff;
    logic [WW-1:0]    c_nxt;
    logic [HW-1:0]    r_nxt;
    logic             col_end;
    logic [WW-1:0]    c_dec;
    logic [HW-1:0]    r_dec;

    // memory stage
    logic [LW-1:0]    line_mem [MAX_WIDTH];
    logic [LW-1:0]    r_rdata;
    logic             r_b_valid;
    logic [PIX_W-1:0] r_b_pix;
    logic [CW-1:0]    r_b_addr;
    logic [POS_W-1:0] r_b_row;
    logic [POS_W-1:0] r_b_col;
    logic             r_b_res;
    logic             r_b_last;
    logic             b_adv;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic [PIX_W-1:0] r_win [6];
    logic [SUM_W-1:0] s_top;
    logic [SUM_W-1:0] s_bot;
    logic [SUM_W-1:0] s_rgt;
    logic [SUM_W-1:0] s_lft;
    logic [SUM_W-1:0] gy;
    logic [SUM_W-1:0] gx;
    logic [MAG_W-1:0] mag;

    // output register
    logic             r_out_valid;
    t_res             r_out;

    // ------------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RST;
            r_cfg_h <= HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_cfg_w <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_h <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_cfg_w);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_cfg_h);
            default:          prdata = '0;
        endcase
    end

    assign cfg_w_ext = WW'(r_cfg_w);
    assign cfg_h_ext = HW'(r_cfg_h);
    assign w_lim = (cfg_w_ext < WW'(MIN_SIZE))  ? WW'(MIN_SIZE)  :
                   (cfg_w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : cfg_w_ext;
    assign h_lim = (cfg_h_ext < HW'(MIN_SIZE))   ? HW'(MIN_SIZE)   :
                   (cfg_h_ext > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : cfg_h_ext;

    // ------------------------------------------------------------------------
    // Position and read issue
    // ------------------------------------------------------------------------
    assign b_adv       = r_b_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_b_valid || b_adv;
    assign in_xfer     = i_pix.valid && i_pix.ready;

    always_comb begin
        wrap    = WW'(r_col) >= w_lim;
        c_eff   = wrap ? '0 : WW'(r_col);
        r_pre   = wrap ? HW'(r_row) + HW'(1) : HW'(r_row);
        r_eff   = (r_pre >= h_lim) ? '0 : r_pre;
        c_nxt   = c_eff + WW'(1);
        r_nxt   = r_eff + HW'(1);
        col_end = c_nxt >= w_lim;
        n_col   = col_end ? '0 : c_nxt[CW-1:0];
        if (col_end) begin
            n_row = (r_nxt >= h_lim) ? '0 : r_nxt[RW-1:0];
        end else begin
            n_row = r_eff[RW-1:0];
        end
        c_dec = c_eff - WW'(1);
        r_dec = r_eff - HW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_xfer) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_b_pix  <= i_pix.payload.pixel;
            r_b_addr <= c_eff[CW-1:0];
            r_b_row  <= r_dec[POS_W-1:0];
            r_b_col  <= c_dec[POS_W-1:0];
            r_b_res  <= (r_eff >= HW'(2)) && (c_eff >= WW'(2));
            r_b_last <= (r_eff == h_lim - HW'(1)) && (c_eff == w_lim - WW'(1));
        end
    end

    // ------------------------------------------------------------------------
    // Line memory: {older, newer} per column
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rdata <= line_mem[c_eff[CW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            line_mem[r_b_addr] <= {mid, bot};
        end
    end

    // ------------------------------------------------------------------------
    // Window and gradient
    // ------------------------------------------------------------------------
    assign top = r_rdata[LW-1:PIX_W];
    assign mid = r_rdata[PIX_W-1:0];
    assign bot = r_b_pix;

    always_comb begin
        s_top = SUM_W'(r_win[0]) + (SUM_W'(r_win[3]) << 1) + SUM_W'(top);
        s_bot = SUM_W'(r_win[2]) + (SUM_W'(r_win[5]) << 1) + SUM_W'(bot);
        s_rgt = SUM_W'(top) + (SUM_W'(mid) << 1) + SUM_W'(bot);
        s_lft = SUM_W'(r_win[0]) + (SUM_W'(r_win[1]) << 1) + SUM_W'(r_win[2]);
        gy    = (s_top >= s_bot) ? s_top - s_bot : s_bot - s_top;
        gx    = (s_rgt >= s_lft) ? s_rgt - s_lft : s_lft - s_rgt;
        mag   = MAG_W'(gx) + MAG_W'(gy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (b_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= bot;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_adv) begin
            r_out_valid <= r_b_res;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out.out_row       <= r_b_row;
            r_out.out_col       <= r_b_col;
            r_out.magnitude     <= mag;
            r_out.edge_byte     <= mag[PIX_W-1:0];
            r_out.last_of_frame <= r_b_last;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

// ===== dv/sobel_check_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude scoreboard
// Tracks raster position, line rows and the 3x3 window for every accepted
// pixel, queues the edge result each pixel completes and compares the
// results that leave the block against that queue, oldest first.
// ----------------------------------------------------------------------------
package sobel_check_pkg;

    import sem_pkg::*;

    localparam int LINE_DEPTH = 4096;

    class sobel_scoreboard;
        logic [CFG_W-1:0] width_cfg;
        logic [CFG_W-1:0] height_cfg;
        logic [POS_W-1:0] col_pos;
        logic [POS_W-1:0] row_pos;
        logic [PIX_W-1:0] older_row [LINE_DEPTH];
        logic [PIX_W-1:0] newer_row [LINE_DEPTH];
        logic [PIX_W-1:0] window [6];
        t_res             pending_results [$];
        int               pixels;
        int               checked;
        int               errors;

        function new();
            width_cfg  = WIDTH_RST;
            height_cfg = HEIGHT_RST;
            col_pos    = '0;
            row_pos    = '0;
            foreach (window[k]) window[k] = '0;
            foreach (older_row[k]) begin
                older_row[k] = '0;
                newer_row[k] = '0;
            end
            pixels  = 0;
            checked = 0;
            errors  = 0;
        endfunction

        function logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] v);
            if (v < MIN_SIZE) return CFG_W'(MIN_SIZE);
            if (v > LINE_DEPTH) return CFG_W'(LINE_DEPTH);
            return v;
        endfunction

        function logic [SUM_W-1:0] distance(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            return (a >= b) ? a - b : b - a;
        endfunction

        function void set_reg(logic reg_sel, logic [CFG_W-1:0] value);
            if (reg_sel == REG_IMAGE_WIDTH) begin
                width_cfg = value;
            end else begin
                height_cfg = value;
            end
        endfunction

        function void take_pixel(logic [PIX_W-1:0] px);
            logic [CFG_W-1:0] w;
            logic [CFG_W-1:0] h;
            logic [CFG_W-1:0] c;
            logic [CFG_W-1:0] r;
            logic [PIX_W-1:0] top;
            logic [PIX_W-1:0] mid;
            logic [SUM_W-1:0] upper;
            logic [SUM_W-1:0] lower;
            logic [SUM_W-1:0] right_col;
            logic [SUM_W-1:0] left_col;
            logic [MAG_W-1:0] mag;
            t_res             res;
            w = eff_size(width_cfg);
            h = eff_size(height_cfg);
            c = {1'b0, col_pos};
            r = {1'b0, row_pos};
            if (c >= w) begin
                c = '0;
                r = r + 1'b1;
            end
            if (r >= h) r = '0;
            top = older_row[c[POS_W-1:0]];
            mid = newer_row[c[POS_W-1:0]];
            if (r >= 2 && c >= 2) begin
                upper     = SUM_W'(window[0]) + (SUM_W'(window[3]) << 1) + SUM_W'(top);
                lower     = SUM_W'(window[2]) + (SUM_W'(window[5]) << 1) + SUM_W'(px);
                right_col = SUM_W'(top) + (SUM_W'(mid) << 1) + SUM_W'(px);
                left_col  = SUM_W'(window[0]) + (SUM_W'(window[1]) << 1) + SUM_W'(window[2]);
                mag       = distance(upper, lower) + distance(right_col, left_col);
                res.out_row       = POS_W'(r - 1'b1);
                res.out_col       = POS_W'(c - 1'b1);
                res.magnitude     = mag;
                res.edge_byte     = mag[PIX_W-1:0];
                res.last_of_frame = (r == h - 1'b1) && (c == w - 1'b1);
                pending_results.push_back(res);
            end
            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = top;
            window[4] = mid;
            window[5] = px;
            older_row[c[POS_W-1:0]] = mid;
            newer_row[c[POS_W-1:0]] = px;
            c = c + 1'b1;
            if (c >= w) begin
                c = '0;
                r = r + 1'b1;
                if (r >= h) r = '0;
            end
            col_pos = c[POS_W-1:0];
            row_pos = r[POS_W-1:0];
            pixels++;
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: row %0d col %0d mag %0d",
                         $time, got.out_row, got.out_col, got.magnitude);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                got.magnitude !== want.magnitude || got.edge_byte !== want.edge_byte ||
                got.last_of_frame !== want.last_of_frame) begin
                errors++;
                $display("%0t: mismatch expected row %0d col %0d mag %0d byte %0d last %0b",
                         $time, want.out_row, want.out_col, want.magnitude,
                         want.edge_byte, want.last_of_frame);
                $display("%0t:          actual   row %0d col %0d mag %0d byte %0d last %0b",
                         $time, got.out_row, got.out_col, got.magnitude,
                         got.edge_byte, got.last_of_frame);
            end
        endfunction
    endclass

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams raster pixels through the block under random source gaps and sink
// stalls, reprograms the image size between bursts (clamped sizes, both
// extremes, mid-frame shrinks and height wraps) and checks every edge result
// against a scoreboard that tracks the same window and line rows.
// ----------------------------------------------------------------------------
module testbench;

    import sem_pkg::*;
    import sobel_check_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE       = 4;
    localparam int HOLD_CYCLES  = 64;
    localparam int WIDE_ITEMS   = 40;
    localparam int RANDOM_ITEMS = 590;
    localparam int TO_FRAME_END = -1;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam logic [CFG_W-1:0] SIZE_MAX = '1;

    localparam logic [PIX_W-1:0] DIRECTED [18] = '{
        8'd0,   8'd255, 8'd255,
        8'd0,   8'd255, 8'd255,
        8'd0,   8'd0,   8'd128,
        8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bit              hold_off_req = 1'b0;
    bit              rx_fast = 1'b0;
    int              geometry_count = 0;
    sobel_scoreboard sb;

    sem_stream_if #(.t_payload(t_pix)) pix_if ();
    sem_stream_if #(.t_payload(t_res)) res_if ();

    sobel_edge_magnitude i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            sb.check_result(res_if.payload);
        end
    end

    initial begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            stall = rx_fast ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1 && !hold_off_req);
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("testbench NOT OK");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px, input int gap);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid         <= 1'b1;
        pix_if.payload.pixel <= px;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        sb.take_pixel(px);
    endtask

    task automatic stream_pixels(input int count, input bit fast);
        int               sent;
        logic [PIX_W-1:0] px;
        sent = 0;
        while ((count < 0) ? (sb.col_pos != 0 || sb.row_pos != 0) : (sent < count)) begin
            case ($urandom_range(0, 5))
                0:       px = '0;
                1:       px = '1;
                default: px = PIX_W'($urandom);
            endcase
            send_pixel(px, fast ? 0 : $urandom_range(0, 7));
            sent++;
        end
        pix_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] word;
        word             = $urandom;
        word[CFG_W-1:0]  = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(reg_sel, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        geometry_count++;
    endtask

    initial begin : stimulus
        int               start;
        int               next_hold;
        bit               fast;
        bit               at_origin;
        logic [CFG_W-1:0] w_new;
        logic [CFG_W-1:0] h_new;
        sb = new();
        i_rst_n              <= 1'b0;
        pix_if.valid         <= 1'b0;
        pix_if.payload.pixel <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two 3x3 frames with undersized registers: strong edge, then flat white
        set_geometry(CFG_W'(0), CFG_W'(2));
        foreach (DIRECTED[k]) send_pixel(DIRECTED[k], $urandom_range(0, 7));
        pix_if.valid <= 1'b0;

        // oversized width, then shrink mid-row so the column wraps early
        set_geometry(SIZE_MAX, CFG_W'(0));
        rx_fast = 1'b1;
        stream_pixels(WIDE_ITEMS, 1'b1);
        rx_fast = 1'b0;
        set_geometry(CFG_W'(5), SIZE_MAX);

        start     = sb.pixels;
        next_hold = 150;
        while (sb.pixels - start < RANDOM_ITEMS) begin
            fast = ($urandom_range(0, 3) == 0);
            if (sb.pixels - start >= next_hold) begin
                hold_off_req = 1'b1;
                fast         = 1'b1;
                next_hold    = next_hold + 250;
            end
            rx_fast = fast;
            stream_pixels($urandom_range(10, 90), fast);
            rx_fast = 1'b0;
            wait_idle();
            at_origin = (sb.col_pos == 0 && sb.row_pos == 0);
            if (!at_origin && $urandom_range(0, 1) == 1 &&
                sb.eff_size(sb.width_cfg) * sb.eff_size(sb.height_cfg) <= 240) begin
                stream_pixels(TO_FRAME_END, 1'b0);
                at_origin = 1'b1;
            end
            case ($urandom_range(0, 19))
                0:       w_new = CFG_W'($urandom_range(0, 2));
                1:       w_new = SIZE_MAX;
                2:       w_new = CFG_W'($urandom_range(13, 400));
                default: w_new = CFG_W'($urandom_range(3, 12));
            endcase
            // widen only at a frame start so no unwritten line entry is read
            if (!at_origin && sb.eff_size(w_new) > sb.eff_size(sb.width_cfg)) begin
                w_new = CFG_W'($urandom_range(0, sb.eff_size(sb.width_cfg)));
            end
            case ($urandom_range(0, 19))
                0:       h_new = CFG_W'($urandom_range(0, 2));
                1:       h_new = SIZE_MAX;
                2:       h_new = CFG_W'($urandom_range(11, 300));
                default: h_new = CFG_W'($urandom_range(3, 10));
            endcase
            set_geometry(w_new, h_new);
        end

        wait_idle();
        repeat (2 * SETTLE) @(posedge i_clk);
        $display("streamed %0d pixels over %0d size settings (clamped, maximal, mid-frame)",
                 sb.pixels, geometry_count);
        $display("compared %0d edge results, %0d failures", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
